// File: src/edit_distance_engine_core_defines.svh
// Assertion macros shared by the edit distance engine RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef EDIT_DISTANCE_ENGINE_CORE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define EDC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// cond must never be true at a clock edge outside reset
`define EDC_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`else

`define EDC_ASSERT(lbl, clk, rstn, prop, msg)

`define EDC_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: src/edc_pkg.sv
// Shared types, codes and sizes for the edit distance engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package edc_pkg;

    localparam int MAX_LEN_DEF     = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int MODE_W   = 2;
    localparam int SYM_W    = 8;
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = 127;

    localparam logic [MODE_W-1:0] MODE_APPEND_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE  = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND_A,
        OP_APPEND_B,
        OP_COMPUTE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [SYM_W-1:0] symbol;
    } item_t;

    // one classified beat with its valid mark
    typedef struct packed {
        logic  valid;
        item_t item;
    } item_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW_START,
        ST_CELL
    } back_state_t;

endpackage

`default_nettype wire

// File: src/edit_distance_engine_core.sv
// Top level of the Levenshtein edit distance engine.
// Depends on edc_pkg, edc_front, edc_queue and edc_back.
`default_nettype none

// Command beats (start high while busy low) append a byte to string A
// (mode 0) or string B (mode 1), or ask for the distance (mode 2); mode 3
// is accepted and ignored. Each string holds MAX_LEN bytes; further appends
// are dropped and set the overflow flag of the job. A request produces one
// result beat: done is high for exactly one cycle with distance and overflow,
// and the receiver cannot stall it. The request then empties both strings.
// Timing: the back end takes an append in its idle state. A request with strings
// of n1 and n2 bytes runs n1 rows in the back end; each row has a row-start
// step to fetch the row's A byte, then n2 DP cells at one cell per cycle; with
// an empty string the result is given from the idle state, with no DP run.
// The result strobe comes in the cycle after the last cell. A front register
// and a QUEUE_DEPTH-deep queue buffer commands, so appends behind a request
// are taken while it runs; busy rises only when both are full.
module edit_distance_engine_core
    import edc_pkg::*;
#(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [SYM_W-1:0]  symbol,
    output logic                   done,
    output logic [DIST_W-1:0]      distance,
    output logic                   overflow
);

    item_beat_t push_beat;   // front -> queue
    item_beat_t head;        // queue -> back
    logic       q_full;
    logic       pop;

    // decode and drop unused modes
    edc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (mode),
        .symbol    (symbol),
        .q_full    (q_full),
        .busy      (busy),
        .push_beat (push_beat)
    );

    // decouples command intake from the long DP runs
    edc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_beat (push_beat),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    // string stores, cost row and the DP sequencer
    edc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .done     (done),
        .distance (distance),
        .overflow (overflow)
    );

endmodule

`default_nettype wire

// File: src/edc_queue.sv
// Small FIFO of classified beats between the front and back ends.
// Depends on edc_pkg and the shared assertion macros.
`default_nettype none
`include "edit_distance_engine_core_defines.svh"

module edc_queue
    import edc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire item_beat_t push_beat,
    input  wire logic       pop,
    output logic            full,
    output item_beat_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    item_t            entry_q [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_q[rd_ptr_reg];

    assign do_push = push_beat.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNTW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNTW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_q[wr_ptr_reg] <= push_beat.item;
        end
    end

    `EDC_ASSERT(a_q_ptrs, clk, rst_n, (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers out of step")
    `EDC_NEVER(a_q_pop_empty, clk, rst_n, pop && !head.valid, "pop from empty queue")
    `EDC_ASSERT(a_q_count, clk, rst_n, count_reg <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

// File: src/edc_front.sv
// Front end: takes command beats, decodes the mode and drops unused codes.
// Depends on edc_pkg; feeds edc_queue.
`default_nettype none

module edc_front
    import edc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic              q_full,
    output logic                   busy,
    output item_beat_t             push_beat
);

    logic  vld_reg, vld_next;
    item_t item_reg, item_next;
    logic  accept;
    logic  known;
    op_t   op_dec;
    logic  push;

    assign busy   = vld_reg && q_full;
    assign accept = start && !busy;
    assign push   = vld_reg && !q_full;

    assign push_beat.valid = vld_reg;
    assign push_beat.item  = item_reg;

    always_comb
    begin
        known  = 1'b1;
        op_dec = OP_APPEND_A;
        unique case (mode)
            MODE_APPEND_A: op_dec = OP_APPEND_A;
            MODE_APPEND_B: op_dec = OP_APPEND_B;
            MODE_COMPUTE:  op_dec = OP_COMPUTE;
            default:       known  = 1'b0;
        endcase
    end

    always_comb
    begin
        item_next = item_reg;
        vld_next  = vld_reg;
        if (push)
        begin
            vld_next = 1'b0;
        end
        // unused mode codes are taken and thrown away here
        if (accept && known)
        begin
            vld_next         = 1'b1;
            item_next.op     = op_dec;
            item_next.symbol = symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// File: src/edc_back.sv
// Back end: string stores, cost row memory and the cell-by-cell DP sequencer.
// Depends on edc_pkg and the shared assertion macros.
`default_nettype none
`include "edit_distance_engine_core_defines.svh"

module edc_back
    import edc_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire item_beat_t  head,
    output logic             pop,
    output logic             done,
    output logic [DIST_W-1:0] distance,
    output logic             overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = (LW > DIST_W) ? LW : DIST_W;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
    localparam logic [LW-1:0] ONE     = LW'(1);

    // stores
    logic [SYM_W-1:0] str_a_mem [MAX_LEN];
    logic [SYM_W-1:0] str_b_mem [MAX_LEN];
    logic [LW-1:0]    row_mem   [MAX_LEN];

    logic [SYM_W-1:0] a_rd_reg;
    logic [SYM_W-1:0] b_rd_reg;
    logic [LW-1:0]    row_rd_reg;

    logic             a_we, b_we, a_re, row_we;
    logic [AW-1:0]    a_waddr, b_waddr, a_raddr, b_raddr, row_raddr, row_waddr;

    back_state_t      state_reg, state_next;
    logic [LW-1:0]    len_a_reg, len_a_next;
    logic [LW-1:0]    len_b_reg, len_b_next;
    logic             ovf_reg, ovf_next;
    logic [LW-1:0]    i_reg, i_next;
    logic [LW-1:0]    j_reg, j_next;
    logic [LW-1:0]    diag_reg, diag_next;
    logic [LW-1:0]    left_reg, left_next;
    logic             done_reg, done_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic             ovf_out_reg, ovf_out_next;

    logic [LW-1:0]    above;
    logic [LW-1:0]    min_dl;
    logic [LW-1:0]    min_all;
    logic [LW-1:0]    cell_cost;
    logic             last_col;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [LW-1:0] val);
        logic [CW-1:0] ext;
        ext = CW'(val);
        return (ext > CW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : ext[DIST_W-1:0];
    endfunction

    assign done     = done_reg;
    assign distance = dist_reg;
    assign overflow = ovf_out_reg;

    // one DP cell; the first row's "above" is the implicit initial row j
    assign above     = (i_reg == ONE) ? j_reg : row_rd_reg;
    assign min_dl    = (diag_reg < left_reg) ? diag_reg : left_reg;
    assign min_all   = (min_dl < above) ? min_dl : above;
    assign cell_cost = (a_rd_reg == b_rd_reg) ? diag_reg : LW'(min_all + 1'b1);
    assign last_col  = (j_reg == len_b_reg);

    always_comb
    begin
        state_next   = state_reg;
        len_a_next   = len_a_reg;
        len_b_next   = len_b_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        diag_next    = diag_reg;
        left_next    = left_reg;
        done_next    = 1'b0;
        dist_next    = dist_reg;
        ovf_out_next = ovf_out_reg;
        pop          = 1'b0;
        a_we         = 1'b0;
        b_we         = 1'b0;
        a_re         = 1'b0;
        row_we       = 1'b0;
        a_waddr      = AW'(len_a_reg);
        b_waddr      = AW'(len_b_reg);
        a_raddr      = AW'(i_reg - 1'b1);
        b_raddr      = '0;
        row_raddr    = '0;
        row_waddr    = AW'(j_reg - 1'b1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    case (head.item.op)
                        OP_APPEND_A:
                        begin
                            if (len_a_reg < LEN_MAX)
                            begin
                                a_we       = 1'b1;
                                len_a_next = LW'(len_a_reg + 1'b1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_APPEND_B:
                        begin
                            if (len_b_reg < LEN_MAX)
                            begin
                                b_we       = 1'b1;
                                len_b_next = LW'(len_b_reg + 1'b1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_COMPUTE:
                        begin
                            if (len_a_reg == '0 || len_b_reg == '0)
                            begin
                                // empty side: distance is the other length
                                done_next    = 1'b1;
                                dist_next    = sat_dist((len_a_reg == '0) ? len_b_reg
                                                                           : len_a_reg);
                                ovf_out_next = ovf_reg;
                                len_a_next   = '0;
                                len_b_next   = '0;
                                ovf_next     = 1'b0;
                            end
                            else
                            begin
                                i_next     = ONE;
                                state_next = ST_ROW_START;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ROW_START:
            begin
                // fetch a[i-1], b[0] and the old row entry for column 1
                a_re       = 1'b1;
                j_next     = ONE;
                diag_next  = LW'(i_reg - 1'b1);
                left_next  = i_reg;
                state_next = ST_CELL;
            end

            ST_CELL:
            begin
                row_we    = 1'b1;
                b_raddr   = last_col ? '0 : AW'(j_reg);
                row_raddr = last_col ? '0 : AW'(j_reg);
                if (last_col)
                begin
                    if (i_reg == len_a_reg)
                    begin
                        done_next    = 1'b1;
                        dist_next    = sat_dist(cell_cost);
                        ovf_out_next = ovf_reg;
                        len_a_next   = '0;
                        len_b_next   = '0;
                        ovf_next     = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = LW'(i_reg + 1'b1);
                        state_next = ST_ROW_START;
                    end
                end
                else
                begin
                    j_next    = LW'(j_reg + 1'b1);
                    left_next = cell_cost;
                    diag_next = above;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_a_reg   <= '0;
            len_b_reg   <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_a_reg   <= len_a_next;
            len_b_reg   <= len_b_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diag_reg    <= diag_next;
        left_reg    <= left_next;
        dist_reg    <= dist_next;
        ovf_out_reg <= ovf_out_next;
    end

    // memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            str_a_mem[a_waddr] <= head.item.symbol;
        end
        if (a_re)
        begin
            a_rd_reg <= str_a_mem[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            str_b_mem[b_waddr] <= head.item.symbol;
        end
        b_rd_reg <= str_b_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= cell_cost;
        end
        row_rd_reg <= row_mem[row_raddr];
    end

    `EDC_ASSERT(a_done_idle, clk, rst_n, done_reg |-> (state_reg == ST_IDLE), "strobe outside idle")
    `EDC_ASSERT(a_cell_range, clk, rst_n, (state_reg == ST_CELL) |-> (j_reg != '0 && j_reg <= len_b_reg && i_reg != '0 && i_reg <= len_a_reg), "cell index out of range")
    `EDC_ASSERT(a_len_bound, clk, rst_n, (len_a_reg <= LEN_MAX) && (len_b_reg <= LEN_MAX), "length beyond capacity")
    `EDC_ASSERT(a_done_clears, clk, rst_n, done_reg |-> (len_a_reg == '0 && len_b_reg == '0 && !ovf_reg), "job not cleared after result")

endmodule

`default_nettype wire

// File: verif/edit_distance_engine_core_tb.sv
// Self-checking testbench for edit_distance_engine_core (Levenshtein distance engine).
// Depends on edc_pkg and the engine RTL; an in-bench predictor supplies the expected results.
`timescale 1ns / 100ps

module edit_distance_engine_core_tb;

    import edc_pkg::*;

    localparam int STR_DEPTH = MAX_LEN_DEF;
    // mode 3 carries no operation; the engine takes the beat and drops it
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 32;

    logic              clk    = 1'b0;
    logic              rst_n  = 1'b0;
    logic              start  = 1'b0;
    logic [MODE_W-1:0] mode   = MODE_APPEND_A;
    logic [SYM_W-1:0]  symbol = '0;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic              ovf;
    } job_result_t;

    // distances still owed by the engine, oldest first
    job_result_t pending_results[$];

    // predictor copy of the job being built
    logic [SYM_W-1:0] str_a [STR_DEPTH];
    logic [SYM_W-1:0] str_b [STR_DEPTH];
    int               len_a;
    int               len_b;
    bit               dropped;

    int idle_pct;
    int beats_sent;
    int jobs_sent;
    int results_seen;
    int failures;
    int cycle_count;

    edit_distance_engine_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .symbol   (symbol),
        .done     (done),
        .distance (distance),
        .overflow (overflow)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void note_failure(string msg);
        if (failures < 10)
            $display("%s", msg);
        failures++;
    endfunction

    // Levenshtein distance of the current strings, one cost row swept per A symbol
    function automatic logic [DIST_W-1:0] edit_cost();
        int row [0:STR_DEPTH];
        int i;
        int j;
        int diag;
        int above;
        int best;
        for (j = 0; j <= len_b; j++)
            row[j] = j;
        for (i = 1; i <= len_a; i++)
        begin
            diag   = row[0];
            row[0] = i;
            for (j = 1; j <= len_b; j++)
            begin
                above = row[j];
                if (str_a[i-1] == str_b[j-1])
                    row[j] = diag;
                else
                begin
                    best = diag;
                    if (above < best)
                        best = above;
                    if (row[j-1] < best)
                        best = row[j-1];
                    row[j] = best + 1;
                end
                diag = above;
            end
        end
        best = (row[len_b] > DIST_MAX) ? DIST_MAX : row[len_b];
        return DIST_W'(best);
    endfunction

    // narrow alphabet makes matches likely, wide one covers every symbol bit
    function automatic logic [SYM_W-1:0] pick_symbol(bit narrow);
        if (narrow)
            return SYM_W'(8'h61 + $urandom_range(3));
        return SYM_W'($urandom_range(255));
    endfunction

    // One command beat: optional sender gap, hold start until busy is low at an edge,
    // then advance the predictor.
    task automatic send_beat(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s);
        int          gap;
        job_result_t res;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        mode   <= m;
        symbol <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (m)
            MODE_APPEND_A:
            begin
                if (len_a < STR_DEPTH)
                begin
                    str_a[len_a] = s;
                    len_a++;
                end
                else
                    dropped = 1'b1;
            end
            MODE_APPEND_B:
            begin
                if (len_b < STR_DEPTH)
                begin
                    str_b[len_b] = s;
                    len_b++;
                end
                else
                    dropped = 1'b1;
            end
            MODE_COMPUTE:
            begin
                res.dist_val    = edit_cost();
                res.ovf         = dropped;
                pending_results = {pending_results, res};
                len_a   = 0;
                len_b   = 0;
                dropped = 1'b0;
                jobs_sent++;
            end
            default: ;
        endcase
        if (m != MODE_IGNORED)
            beats_sent++;
    endtask

    // drop start in the step of the last acceptance so nothing is taken twice
    task automatic go_quiet();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Small hand-picked jobs: empty strings, extreme symbols, ignored mode,
    // identical strings and a short mixed edit.
    task automatic test_corner_jobs();
        string sa;
        string sb;
        int    k;
        idle_pct = 0;
        send_beat(MODE_COMPUTE, 8'hFF);             // both empty
        send_beat(MODE_APPEND_A, 8'h00);
        send_beat(MODE_COMPUTE, 8'h00);             // B empty
        send_beat(MODE_APPEND_B, 8'hFF);
        send_beat(MODE_APPEND_B, 8'h00);
        send_beat(MODE_COMPUTE, 8'h55);             // A empty
        send_beat(MODE_APPEND_A, 8'hFF);
        send_beat(MODE_APPEND_A, 8'h00);
        send_beat(MODE_IGNORED, 8'hFF);             // must not land in A
        send_beat(MODE_APPEND_B, 8'h00);
        send_beat(MODE_APPEND_B, 8'hFF);
        send_beat(MODE_COMPUTE, 8'hAA);
        send_beat(MODE_APPEND_A, 8'h41);
        send_beat(MODE_APPEND_B, 8'h41);
        send_beat(MODE_COMPUTE, 8'h00);             // identical
        sa = "abc";
        sb = "yabd";
        for (k = 0; k < sa.len(); k++)
            send_beat(MODE_APPEND_A, sa[k]);
        for (k = 0; k < sb.len(); k++)
            send_beat(MODE_APPEND_B, sb[k]);
        send_beat(MODE_COMPUTE, 8'h00);
        go_quiet();
    endtask

    // Full strings: drops past the end set overflow, the widest compute runs,
    // and the flag clears for the following job.
    task automatic test_full_strings();
        logic [SYM_W-1:0] pattern [STR_DEPTH];
        int               k;
        idle_pct = 18;
        for (k = 0; k < STR_DEPTH + 2; k++)
            send_beat(MODE_APPEND_A, pick_symbol(k[0]));
        for (k = 0; k < STR_DEPTH; k++)
            send_beat(MODE_APPEND_B, pick_symbol(k[1]));
        send_beat(MODE_COMPUTE, 8'h00);
        for (k = 0; k < STR_DEPTH + 1; k++)
            send_beat(MODE_APPEND_B, pick_symbol(1'b0));
        send_beat(MODE_COMPUTE, 8'h00);
        for (k = 0; k < STR_DEPTH; k++)
            pattern[k] = pick_symbol(1'b0);
        for (k = 0; k < STR_DEPTH; k++)
            send_beat(MODE_APPEND_A, pattern[k]);
        for (k = 0; k < STR_DEPTH; k++)
            send_beat(MODE_APPEND_B, pattern[k]);
        send_beat(MODE_COMPUTE, 8'h00);
        go_quiet();
    endtask

    // Mostly well-formed jobs with random content and lengths, a few long ones
    // that can overflow, plus stray ignored beats and unstructured streams.
    task automatic test_random_jobs(input int target, input int pct);
        int  stop_at;
        int  kind;
        int  na;
        int  nb;
        int  n;
        bit  narrow;
        idle_pct = pct;
        stop_at  = beats_sent + target;
        while (beats_sent < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 6)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_beat(MODE_W'($urandom_range(3)), pick_symbol(1'b0));
            end
            else
            begin
                if (kind < 10)
                begin
                    na = $urandom_range(STR_DEPTH - 16, STR_DEPTH + 4);
                    nb = $urandom_range(STR_DEPTH - 16, STR_DEPTH + 4);
                end
                else
                begin
                    na = $urandom_range(0, 10);
                    nb = $urandom_range(0, 10);
                end
                narrow = ($urandom_range(3) != 0);
                while (na > 0 || nb > 0)
                begin
                    if ($urandom_range(99) < 3)
                        send_beat(MODE_IGNORED, pick_symbol(1'b0));
                    if (nb == 0 || (na > 0 && $urandom_range(1) == 0))
                    begin
                        send_beat(MODE_APPEND_A, pick_symbol(narrow));
                        na--;
                    end
                    else
                    begin
                        send_beat(MODE_APPEND_B, pick_symbol(narrow));
                        nb--;
                    end
                end
                send_beat(MODE_COMPUTE, pick_symbol(1'b0));
            end
        end
        go_quiet();
    endtask

    // Result strobe lasts one cycle; sample it at the edge that ends it.
    always @(posedge clk)
    begin : result_check
        job_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result: distance %0d overflow %0b",
                                       distance, overflow));
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (distance !== want.dist_val || overflow !== want.ovf)
                    note_failure($sformatf(
                        "result %0d: expected distance %0d overflow %0b, got %0d %0b",
                        results_seen, want.dist_val, want.ovf, distance, overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("edit_distance_engine_core test failed");
            $finish;
        end
    end

    initial
    begin
        len_a        = 0;
        len_b        = 0;
        dropped      = 1'b0;
        idle_pct     = 0;
        beats_sent   = 0;
        jobs_sent    = 0;
        results_seen = 0;
        failures     = 0;
        cycle_count  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_jobs();
        test_full_strings();
        test_random_jobs(450, 0);
        test_random_jobs(450, 47);
        test_random_jobs(450, 18);

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d command beats and %0d distance jobs, %0d results checked",
                 beats_sent, jobs_sent, results_seen);
        $display("corner strings, full-string overflow, random jobs under sender gaps; %0d failures",
                 failures);
        if (failures == 0)
            $display("edit_distance_engine_core test passed");
        else
            $display("edit_distance_engine_core test failed");
        $finish;
    end

endmodule

// File: edit_distance_engine_core.f
+incdir+src
src/edc_pkg.sv
src/edc_queue.sv
src/edc_front.sv
src/edc_back.sv
src/edit_distance_engine_core.sv
verif/edit_distance_engine_core_tb.sv
